// File: design/cnsp_pkg.sv
`timescale 1ns / 1ps

package cnsp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam int unsigned LIMIT_W             = 18;

    localparam logic [LIMIT_W-1:0] NAME_LIMIT_RESET = 18'd131072;

    localparam logic [6:0] HDR_BYTES   = 7'd110;
    localparam logic [6:0] MAGIC_BYTES = 7'd6;

    localparam logic [3:0] FIELD_FILESIZE = 4'd6;
    localparam logic [3:0] FIELD_NAMESIZE = 4'd11;
    localparam logic [3:0] FIELD_CHECK    = 4'd12;

    localparam logic [3:0] TRAILER_CHARS = 4'd10;
    localparam logic [3:0] TRAILER_LEN   = 4'd11;

    localparam logic [0:0] CFG_IDX_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        KIND_FRAME = 3'd0,
        KIND_FIELD = 3'd1,
        KIND_NAME  = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_END   = 3'd4,
        KIND_ERROR = 3'd5
    } cnsp_kind_t;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_NONHEX    = 4'd2;
    localparam logic [3:0] ERR_CHECK     = 4'd3;
    localparam logic [3:0] ERR_NAMESIZE  = 4'd4;
    localparam logic [3:0] ERR_NUL       = 4'd5;
    localparam logic [3:0] ERR_PADDING   = 4'd6;
    localparam logic [3:0] ERR_TRAILER   = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED = 4'd8;

    // One classified input beat as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_zero;
    } cnsp_beat_t;

    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                3'd1:    c = 8'h37;
                3'd3:    c = 8'h37;
                3'd5:    c = 8'h31;
                default: c = 8'h30;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                4'd0:    c = 8'h54;
                4'd1:    c = 8'h52;
                4'd2:    c = 8'h41;
                4'd3:    c = 8'h49;
                4'd4:    c = 8'h4C;
                4'd5:    c = 8'h45;
                4'd6:    c = 8'h52;
                default: c = 8'h21;
            endcase
            return c;
        end
    endfunction

endpackage

// File: design/cnsp_front.sv
`timescale 1ns / 1ps

module cnsp_front
    import cnsp_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    input  logic       q_full,
    output logic       q_push,
    output cnsp_beat_t q_beat
);

    logic       hex_ok;
    logic [3:0] hex_val;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_val = data_byte[3:0];
        end
        else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h66))
        begin
            hex_val = data_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign q_beat.data    = data_byte;
    assign q_beat.last    = stream_end;
    assign q_beat.hex_ok  = hex_ok;
    assign q_beat.hex_val = hex_val;
    assign q_beat.is_zero = (data_byte == 8'h00);

endmodule

// File: design/cnsp_queue.sv
`timescale 1ns / 1ps

module cnsp_queue
    import cnsp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cnsp_beat_t push_beat,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output cnsp_beat_t pop_beat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cnsp_beat_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_beat  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_beat;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue popped while empty");

endmodule

// File: design/cnsp_back.sv
`timescale 1ns / 1ps

module cnsp_back
    import cnsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cnsp_beat_t         q_beat,
    output logic               q_pop,
    input  logic [LIMIT_W-1:0] name_size_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         item_kind,
    output logic [3:0]         field_index,
    output logic [31:0]        field_value,
    output logic [7:0]         payload_byte,
    output logic [3:0]         error_code
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_TAIL,
        PH_ENDED,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  hdr_pos_reg, hdr_pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] name_len_reg, name_len_next;
    logic [31:0] content_reg, content_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  pad_reg, pad_next;
    logic        nul_reg, nul_next;
    logic        trl_reg, trl_next;
    logic [3:0]  name_pos_reg, name_pos_next;
    logic [3:0]  err_reg, err_next;

    logic        out_valid_reg, out_valid_next;
    cnsp_kind_t  kind_reg, kind_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] val_reg, val_next;
    logic [7:0]  pay_reg, pay_next;
    logic [3:0]  code_reg, code_next;

    logic        fire;

    assign fire  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = fire;

    always_comb
    begin
        logic [3:0]  fail_code;
        logic        do_after;
        logic        trl_eff;
        logic [1:0]  pad_calc;
        logic [6:0]  off;
        logic [3:0]  fidx;
        logic [31:0] acc_new;

        phase_next    = phase_reg;
        hdr_pos_next  = hdr_pos_reg;
        acc_next      = acc_reg;
        name_len_next = name_len_reg;
        content_next  = content_reg;
        remain_next   = remain_reg;
        pad_next      = pad_reg;
        nul_next      = nul_reg;
        trl_next      = trl_reg;
        name_pos_next = name_pos_reg;
        err_next      = err_reg;

        kind_next = KIND_FRAME;
        idx_next  = 4'd0;
        val_next  = 32'd0;
        pay_next  = 8'd0;
        code_next = ERR_NONE;

        fail_code = ERR_NONE;
        do_after  = 1'b0;
        trl_eff   = trl_reg;
        pad_calc  = 2'd0;
        off       = hdr_pos_reg - MAGIC_BYTES;
        fidx      = off[6:3];
        acc_new   = {acc_reg[27:0], q_beat.hex_val};

        if (phase_reg == PH_ERROR)
        begin
            kind_next = KIND_ERROR;
            code_next = err_reg;
        end
        else if (phase_reg == PH_ENDED)
        begin
            kind_next = KIND_END;
        end
        else if (q_beat.last)
        begin
            if (phase_reg == PH_TAIL)
            begin
                phase_next = PH_ENDED;
                kind_next  = KIND_END;
            end
            else
            begin
                fail_code = ERR_TRUNCATED;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_pos_reg < MAGIC_BYTES)
                    begin
                        if (q_beat.data != magic_char(hdr_pos_reg[2:0]))
                        begin
                            fail_code = ERR_MAGIC;
                        end
                        hdr_pos_next = hdr_pos_reg + 7'd1;
                    end
                    else if (!q_beat.hex_ok)
                    begin
                        fail_code = ERR_NONHEX;
                    end
                    else
                    begin
                        hdr_pos_next = hdr_pos_reg + 7'd1;
                        if (off[2:0] != 3'b111)
                        begin
                            acc_next = acc_new;
                        end
                        else
                        begin
                            acc_next  = 32'd0;
                            kind_next = KIND_FIELD;
                            idx_next  = fidx;
                            val_next  = acc_new;
                            if (fidx == FIELD_FILESIZE)
                            begin
                                content_next = acc_new;
                            end
                            if (fidx == FIELD_NAMESIZE)
                            begin
                                name_len_next = acc_new;
                            end
                            if (fidx == FIELD_CHECK)
                            begin
                                if (acc_new != 32'd0)
                                begin
                                    fail_code = ERR_CHECK;
                                end
                                else if (name_len_reg < 32'd2 ||
                                         name_len_reg > {14'd0, name_size_limit})
                                begin
                                    fail_code = ERR_NAMESIZE;
                                end
                                else
                                begin
                                    phase_next    = PH_NAME;
                                    remain_next   = name_len_reg;
                                    nul_next      = 1'b0;
                                    trl_next      = 1'b1;
                                    name_pos_next = 4'd0;
                                end
                            end
                        end
                    end
                end
                PH_NAME:
                begin
                    if (name_pos_reg < TRAILER_CHARS &&
                        q_beat.data != trailer_char(name_pos_reg))
                    begin
                        trl_eff = 1'b0;
                    end
                    if (name_pos_reg == TRAILER_CHARS && !q_beat.is_zero)
                    begin
                        trl_eff = 1'b0;
                    end
                    trl_next = trl_eff;
                    if (name_pos_reg != TRAILER_LEN)
                    begin
                        name_pos_next = name_pos_reg + 4'd1;
                    end
                    if (q_beat.is_zero)
                    begin
                        nul_next = 1'b1;
                    end
                    else if (nul_reg || remain_reg == 32'd1)
                    begin
                        fail_code = ERR_NUL;
                    end
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        pad_calc   = 2'd0 - (2'd2 + name_len_reg[1:0]);
                        pad_next   = pad_calc;
                        phase_next = PH_NAME_PAD;
                        do_after   = (pad_calc == 2'd0);
                    end
                    kind_next = KIND_NAME;
                    pay_next  = q_beat.data;
                end
                PH_NAME_PAD:
                begin
                    if (!q_beat.is_zero)
                    begin
                        fail_code = ERR_PADDING;
                    end
                    pad_next = pad_reg - 2'd1;
                    do_after = (pad_reg == 2'd1);
                end
                PH_DATA:
                begin
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        pad_calc = 2'd0 - content_reg[1:0];
                        pad_next = pad_calc;
                        if (pad_calc == 2'd0)
                        begin
                            phase_next   = PH_HEADER;
                            hdr_pos_next = 7'd0;
                            acc_next     = 32'd0;
                        end
                        else
                        begin
                            phase_next = PH_DATA_PAD;
                        end
                    end
                    kind_next = KIND_DATA;
                    pay_next  = q_beat.data;
                end
                PH_DATA_PAD:
                begin
                    if (!q_beat.is_zero)
                    begin
                        fail_code = ERR_PADDING;
                    end
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        phase_next   = PH_HEADER;
                        hdr_pos_next = 7'd0;
                        acc_next     = 32'd0;
                    end
                end
                PH_TAIL:
                begin
                    if (!q_beat.is_zero)
                    begin
                        fail_code = ERR_TRAILER;
                    end
                end
                default:
                begin
                    kind_next = KIND_END;
                end
            endcase

            // The name and its padding are complete: pick what follows.
            if (do_after && fail_code == ERR_NONE)
            begin
                if (trl_eff && name_len_reg >= {28'd0, TRAILER_LEN})
                begin
                    if (content_reg != 32'd0)
                    begin
                        fail_code = ERR_TRAILER;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                else if (content_reg == 32'd0)
                begin
                    phase_next   = PH_HEADER;
                    hdr_pos_next = 7'd0;
                    acc_next     = 32'd0;
                    pad_next     = 2'd0;
                end
                else
                begin
                    phase_next  = PH_DATA;
                    remain_next = content_reg;
                end
            end
        end

        if (fail_code != ERR_NONE)
        begin
            phase_next = PH_ERROR;
            err_next   = fail_code;
            kind_next  = KIND_ERROR;
            idx_next   = 4'd0;
            val_next   = 32'd0;
            pay_next   = 8'd0;
            code_next  = fail_code;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_pos_reg   <= 7'd0;
            acc_reg       <= 32'd0;
            name_len_reg  <= 32'd0;
            content_reg   <= 32'd0;
            remain_reg    <= 32'd0;
            pad_reg       <= 2'd0;
            nul_reg       <= 1'b0;
            trl_reg       <= 1'b1;
            name_pos_reg  <= 4'd0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_FRAME;
            idx_reg       <= 4'd0;
            val_reg       <= 32'd0;
            pay_reg       <= 8'd0;
            code_reg      <= ERR_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg    <= phase_next;
                hdr_pos_reg  <= hdr_pos_next;
                acc_reg      <= acc_next;
                name_len_reg <= name_len_next;
                content_reg  <= content_next;
                remain_reg   <= remain_next;
                pad_reg      <= pad_next;
                nul_reg      <= nul_next;
                trl_reg      <= trl_next;
                name_pos_reg <= name_pos_next;
                err_reg      <= err_next;
                kind_reg     <= kind_next;
                idx_reg      <= idx_next;
                val_reg      <= val_next;
                pay_reg      <= pay_next;
                code_reg     <= code_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign item_kind    = kind_reg;
    assign field_index  = idx_reg;
    assign field_value  = val_reg;
    assign payload_byte = pay_reg;
    assign error_code   = code_reg;

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR && $stable(err_reg))
        else $error("error state left or error code changed");

    a_error_code_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) == (err_reg != ERR_NONE))
        else $error("error code and error state disagree");

    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> hdr_pos_reg < HDR_BYTES)
        else $error("header position past end of header");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ENDED |=> phase_reg == PH_ENDED)
        else $error("archive end state left");

endmodule

// File: design/cpio_newc_stream_parser.sv
`timescale 1ns / 1ps

// Streaming parser for newc archives. One byte is taken per beat and one result beat comes
// out for each input beat, so the sustained rate is one byte per clock cycle while out_stall
// does not hold the output. The input side writes each classified byte into a queue of
// QUEUE_DEPTH entries. The parse state machine drains it one entry per cycle, unless out_stall
// holds a valid result, into a registered output, so a result passes through the queue entry
// and the output register before it is offered. That machine's state update sets the rate.
// in_stall rises only when the queue is full because the output side is stalled.

module cpio_newc_stream_parser
    import cnsp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  item_kind,
    output logic [3:0]  field_index,
    output logic [31:0] field_value,
    output logic [7:0]  payload_byte,
    output logic [3:0]  error_code
);

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               cfg_wr;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    cnsp_beat_t push_beat;
    cnsp_beat_t pop_beat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_LIMIT);
    assign prdata = (paddr[2] == CFG_IDX_LIMIT) ? {14'd0, limit_reg} : 32'd0;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_wr)
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= NAME_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    cnsp_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_beat     (push_beat)
    );

    cnsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (push_beat),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_beat  (pop_beat)
    );

    cnsp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_beat          (pop_beat),
        .q_pop           (q_pop),
        .name_size_limit (limit_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .item_kind       (item_kind),
        .field_index     (field_index),
        .field_value     (field_value),
        .payload_byte    (payload_byte),
        .error_code      (error_code)
    );

endmodule

// File: bench/cnsp_result_checker.sv
`timescale 1ns / 1ps

module cnsp_result_checker
    import cnsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  item_kind,
    input  logic [3:0]  field_index,
    input  logic [31:0] field_value,
    input  logic [7:0]  payload_byte,
    input  logic [3:0]  error_code,
    output int          mismatches,
    output int          pending
);

    localparam logic [2:0]  LIMIT_ADDR   = {CFG_IDX_LIMIT, 2'b00};
    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_TAIL,
        PH_ENDED,
        PH_FAILED
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [7:0]  pay;
        logic [3:0]  err;
    } parse_item_t;

    logic [LIMIT_W-1:0] name_limit;
    parse_phase_t       phase;
    logic [6:0]         hdr_pos;
    logic [31:0]        digits;
    logic [31:0]        name_len;
    logic [31:0]        file_len;
    logic [31:0]        remaining;
    logic [1:0]         pad_left;
    logic               saw_nul;
    logic               is_trailer;
    logic [3:0]         latched_err;

    parse_item_t predicted_items[$];
    int          taken_count;
    int          given_count;

    assign pending = taken_count - given_count;

    function automatic parse_item_t make_item(input cnsp_kind_t kind, input logic [3:0] idx,
                                              input logic [31:0] val, input logic [7:0] pay,
                                              input logic [3:0] err);
        parse_item_t r;
        r.kind = kind;
        r.idx  = idx;
        r.val  = val;
        r.pay  = pay;
        r.err  = err;
        return r;
    endfunction

    function automatic parse_item_t raise_error(input logic [3:0] code);
        latched_err = code;
        phase       = PH_FAILED;
        return make_item(KIND_ERROR, 4'd0, 32'd0, 8'd0, code);
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void open_record();
        phase   = PH_HEADER;
        hdr_pos = 7'd0;
        digits  = 32'd0;
    endfunction

    function automatic void open_data_pad();
        pad_left = 2'd0 - file_len[1:0];
        if (pad_left == 2'd0)
            open_record();
        else
            phase = PH_DATA_PAD;
    endfunction

    function automatic logic [3:0] close_name();
        if (is_trailer && name_len >= 32'(TRAILER_LEN))
        begin
            if (file_len != 32'd0)
                return ERR_TRAILER;
            phase = PH_TAIL;
        end
        else if (file_len == 32'd0)
        begin
            open_data_pad();
        end
        else
        begin
            phase     = PH_DATA;
            remaining = file_len;
        end
        return ERR_NONE;
    endfunction

    function automatic parse_item_t parse_archive_byte(input logic [7:0] b, input logic fin);
        logic [4:0]  hv;
        logic [6:0]  pos;
        logic [6:0]  offs;
        logic [3:0]  idx;
        logic [31:0] v;
        logic [31:0] npos;
        logic [31:0] span;
        logic [3:0]  code;
        int          sel;
        if (latched_err != ERR_NONE)
            return make_item(KIND_ERROR, 4'd0, 32'd0, 8'd0, latched_err);
        if (phase == PH_ENDED)
            return make_item(KIND_END, 4'd0, 32'd0, 8'd0, ERR_NONE);
        if (fin)
        begin
            if (phase == PH_TAIL)
            begin
                phase = PH_ENDED;
                return make_item(KIND_END, 4'd0, 32'd0, 8'd0, ERR_NONE);
            end
            return raise_error(ERR_TRUNCATED);
        end
        case (phase)
            PH_HEADER:
            begin
                pos = hdr_pos;
                if (pos < MAGIC_BYTES)
                begin
                    sel = 5 - int'(pos);
                    if (b != MAGIC_TEXT[8*sel +: 8])
                        return raise_error(ERR_MAGIC);
                    hdr_pos = pos + 7'd1;
                    return make_item(KIND_FRAME, 4'd0, 32'd0, 8'd0, ERR_NONE);
                end
                hv = hex_digit(b);
                if (hv[4])
                    return raise_error(ERR_NONHEX);
                digits  = {digits[27:0], hv[3:0]};
                hdr_pos = pos + 7'd1;
                offs    = pos - MAGIC_BYTES;
                if (offs[2:0] != 3'd7)
                    return make_item(KIND_FRAME, 4'd0, 32'd0, 8'd0, ERR_NONE);
                idx    = offs[6:3];
                v      = digits;
                digits = 32'd0;
                if (idx == FIELD_FILESIZE)
                    file_len = v;
                if (idx == FIELD_NAMESIZE)
                    name_len = v;
                if (idx >= FIELD_CHECK || hdr_pos >= HDR_BYTES)
                begin
                    if (v != 32'd0)
                        return raise_error(ERR_CHECK);
                    if (name_len < 32'd2 || name_len > 32'(name_limit))
                        return raise_error(ERR_NAMESIZE);
                    phase      = PH_NAME;
                    remaining  = name_len;
                    saw_nul    = 1'b0;
                    is_trailer = 1'b1;
                end
                return make_item(KIND_FIELD, idx, v, 8'd0, ERR_NONE);
            end
            PH_NAME:
            begin
                npos = name_len - remaining;
                if (npos < 32'(TRAILER_CHARS))
                begin
                    sel = 9 - int'(npos[3:0]);
                    if (b != TRAILER_TEXT[8*sel +: 8])
                        is_trailer = 1'b0;
                end
                else if (npos == 32'(TRAILER_CHARS) && b != 8'd0)
                begin
                    is_trailer = 1'b0;
                end
                if (b == 8'd0)
                    saw_nul = 1'b1;
                else if (saw_nul || remaining == 32'd1)
                    return raise_error(ERR_NUL);
                remaining = remaining - 32'd1;
                if (remaining == 32'd0)
                begin
                    span     = name_len + 32'(HDR_BYTES);
                    pad_left = 2'd0 - span[1:0];
                    phase    = PH_NAME_PAD;
                    if (pad_left == 2'd0)
                    begin
                        code = close_name();
                        if (code != ERR_NONE)
                            return raise_error(code);
                    end
                end
                return make_item(KIND_NAME, 4'd0, 32'd0, b, ERR_NONE);
            end
            PH_NAME_PAD:
            begin
                if (b != 8'd0)
                    return raise_error(ERR_PADDING);
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0)
                begin
                    code = close_name();
                    if (code != ERR_NONE)
                        return raise_error(code);
                end
                return make_item(KIND_FRAME, 4'd0, 32'd0, 8'd0, ERR_NONE);
            end
            PH_DATA:
            begin
                remaining = remaining - 32'd1;
                if (remaining == 32'd0)
                    open_data_pad();
                return make_item(KIND_DATA, 4'd0, 32'd0, b, ERR_NONE);
            end
            PH_DATA_PAD:
            begin
                if (b != 8'd0)
                    return raise_error(ERR_PADDING);
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0)
                    open_record();
                return make_item(KIND_FRAME, 4'd0, 32'd0, 8'd0, ERR_NONE);
            end
            PH_TAIL:
            begin
                if (b != 8'd0)
                    return raise_error(ERR_TRAILER);
                return make_item(KIND_FRAME, 4'd0, 32'd0, 8'd0, ERR_NONE);
            end
            default:
                return make_item(KIND_END, 4'd0, 32'd0, 8'd0, ERR_NONE);
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0h, got %0h", fname, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_item_t want;
        if (!rst_n)
        begin
            name_limit  = NAME_LIMIT_RESET;
            open_record();
            name_len    = 32'd0;
            file_len    = 32'd0;
            remaining   = 32'd0;
            pad_left    = 2'd0;
            saw_nul     = 1'b0;
            is_trailer  = 1'b1;
            latched_err = ERR_NONE;
            mismatches  = 0;
            predicted_items.delete();
            taken_count <= 0;
            given_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                name_limit = pwdata[LIMIT_W-1:0];
            if (out_valid && !out_stall)
            begin
                given_count <= given_count + 1;
                if (predicted_items.size() == 0)
                begin
                    $error("result beat with no byte waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = predicted_items.pop_front();
                    check_field("item_kind", 32'(want.kind), 32'(item_kind));
                    check_field("field_index", 32'(want.idx), 32'(field_index));
                    check_field("field_value", want.val, field_value);
                    check_field("payload_byte", 32'(want.pay), 32'(payload_byte));
                    check_field("error_code", 32'(want.err), 32'(error_code));
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted_items.push_back(parse_archive_byte(data_byte, stream_end));
                taken_count <= taken_count + 1;
            end
        end
    end

endmodule

// File: bench/tb_cpio_newc_stream_parser.sv
`timescale 1ns / 1ps

module tb_cpio_newc_stream_parser;
    import cnsp_pkg::*;

    localparam logic [2:0]  LIMIT_ADDR   = {CFG_IDX_LIMIT, 2'b00};
    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";

    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_NONHEX,
        FLT_CHECK,
        FLT_NAMESIZE,
        FLT_NUL,
        FLT_NAME_PAD,
        FLT_DATA_PAD,
        FLT_TRAILER_DATA,
        FLT_TAIL_JUNK,
        FLT_TRUNCATE
    } record_fault_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  item_kind;
    logic [3:0]  field_index;
    logic [31:0] field_value;
    logic [7:0]  payload_byte;
    logic [3:0]  error_code;
    int          mismatches;
    int          pending;

    int                 beats_sent = 0;
    int                 records_done = 0;
    int                 limit_writes = 0;
    int                 cut_at = -1;
    bit                 calm = 1'b0;
    logic [LIMIT_W-1:0] cur_limit = NAME_LIMIT_RESET;
    logic [7:0]         name_buf[$];
    record_fault_t      ending;

    cpio_newc_stream_parser uut (.*);

    cnsp_result_checker checker_i (.*);

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("tb_cpio_newc_stream_parser failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic fin);
        logic last_beat;
        last_beat = fin || (beats_sent == cut_at);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        stream_end <= last_beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain_parser();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_name_limit(input logic [LIMIT_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_limit = v;
        limit_writes++;
    endtask

    task automatic send_hex(input logic [31:0] v, input int bad_digit);
        logic [3:0] nib;
        logic [7:0] c;
        for (int d = 0; d < 8; d++)
        begin
            nib = v[31-4*d -: 4];
            if (nib < 4'd10)
                c = 8'("0") + 8'(nib);
            else
                c = ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
            if (d == bad_digit)
            begin
                c = 8'($urandom);
                while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                       (c >= "A" && c <= "F"))
                    c = 8'($urandom);
            end
            push_beat(c, 1'b0);
        end
    endtask

    task automatic make_name(input int n, input bit bad_nul);
        int k;
        name_buf.delete();
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
            name_buf.push_back(i < k ? 8'($urandom_range(1, 255)) : 8'd0);
        if (bad_nul)
        begin
            if (k < n - 1 && $urandom_range(0, 1))
                name_buf[$urandom_range(k + 1, n - 1)] = 8'($urandom_range(1, 255));
            else
                name_buf[n - 1] = 8'($urandom_range(1, 255));
        end
    endtask

    task automatic make_trailer(input int n);
        name_buf.delete();
        for (int i = 0; i < n; i++)
            name_buf.push_back(i < 10 ? TRAILER_TEXT[8*(9-i) +: 8] : 8'd0);
    endtask

    task automatic send_record(input logic [31:0] fsize, input logic [31:0] nsize,
                               input record_fault_t flt);
        int          bad_pos;
        int          bad_field;
        int          pads;
        logic [7:0]  c;
        logic [31:0] v;
        bad_pos = (flt == FLT_MAGIC) ? $urandom_range(0, 5) : -1;
        for (int i = 0; i < 6; i++)
        begin
            c = MAGIC_TEXT[8*(5-i) +: 8];
            if (i == bad_pos)
                c = c ^ (8'd1 << $urandom_range(0, 7));
            push_beat(c, 1'b0);
        end
        bad_field = (flt == FLT_NONHEX) ? $urandom_range(0, 12) : -1;
        for (int i = 0; i < 13; i++)
        begin
            case ($urandom_range(0, 3))
                0:       v = 32'd0;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            if (i == FIELD_FILESIZE)
                v = fsize;
            else if (i == FIELD_NAMESIZE)
                v = nsize;
            else if (i == FIELD_CHECK)
                v = (flt == FLT_CHECK) ? ($urandom | 32'd1) : 32'd0;
            send_hex(v, i == bad_field ? int'($urandom_range(0, 7)) : -1);
        end
        foreach (name_buf[i])
            push_beat(name_buf[i], 1'b0);
        pads = (4 - ((110 + int'(nsize[1:0])) & 3)) & 3;
        for (int i = 0; i < pads; i++)
            push_beat((flt == FLT_NAME_PAD && i == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                      1'b0);
        for (int i = 0; i < int'(fsize); i++)
            push_beat(8'($urandom), 1'b0);
        pads = (4 - int'(fsize[1:0])) & 3;
        for (int i = 0; i < pads; i++)
            push_beat((flt == FLT_DATA_PAD && i == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                      1'b0);
        records_done++;
    endtask

    initial
    begin
        int          hi;
        int          nsize;
        int          fsize;
        logic [31:0] bad_size;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_name_limit(18'd2);
        make_name(2, 1'b0);
        send_record(32'd0, 32'd2, FLT_NONE);
        drain_parser();
        set_name_limit(18'd131072);
        // A name that starts like the trailer but is not one.
        make_trailer(12);
        name_buf[9] = "X";
        send_record(32'd3, 32'd12, FLT_NONE);
        make_name(5, 1'b0);
        send_record(32'd1, 32'd5, FLT_NONE);
        make_name(8, 1'b0);
        send_record(32'd6, 32'd8, FLT_NONE);

        while (beats_sent < 1500)
        begin
            if (records_done % 3 == 0)
            begin
                drain_parser();
                case ($urandom_range(0, 5))
                    0:       set_name_limit(18'h3FFFF);
                    1:       set_name_limit(18'd131072);
                    2:       set_name_limit(18'd2);
                    default: set_name_limit(18'($urandom_range(11, 60)));
                endcase
            end
            if (beats_sent >= 1300)
                calm = 1'b1;
            hi = ($urandom_range(0, 9) == 0) ? 200 : 24;
            if (int'(cur_limit) < hi)
                hi = int'(cur_limit);
            nsize = ($urandom_range(0, 5) == 0) ? hi : int'($urandom_range(2, hi));
            fsize = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 64))
                                                : int'($urandom_range(0, 12));
            make_name(nsize, 1'b0);
            send_record(32'(fsize), 32'(nsize), FLT_NONE);
        end

        calm = 1'b1;
        if (cur_limit < 18'd14)
        begin
            drain_parser();
            set_name_limit(18'($urandom_range(14, 100)));
        end
        ending = record_fault_t'($urandom_range(0, FLT_TRUNCATE));
        case (ending)
            FLT_NONE, FLT_TAIL_JUNK, FLT_TRAILER_DATA:
            begin
                make_trailer($urandom_range(11, 14));
                fsize = (ending == FLT_TRAILER_DATA) ? int'($urandom_range(1, 9)) : 0;
                send_record(32'(fsize), 32'(name_buf.size()), FLT_NONE);
                repeat ($urandom_range(0, 6)) push_beat(8'd0, 1'b0);
                if (ending == FLT_TAIL_JUNK)
                    push_beat(8'($urandom_range(1, 255)), 1'b0);
            end
            FLT_NAMESIZE:
            begin
                case ($urandom_range(0, 2))
                    0:       bad_size = 32'd0;
                    1:       bad_size = 32'd1;
                    default: bad_size = 32'(cur_limit) + 32'd1;
                endcase
                make_name(4, 1'b0);
                send_record(32'd2, bad_size, FLT_NAMESIZE);
            end
            default:
            begin
                nsize = $urandom_range(2, 13);
                if (ending == FLT_NAME_PAD && ((110 + nsize) & 3) == 0)
                    nsize++;
                fsize = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
                if (ending == FLT_TRUNCATE)
                    cut_at = beats_sent + $urandom_range(0, 160);
                make_name(nsize, ending == FLT_NUL);
                send_record(32'(fsize), 32'(nsize), ending);
            end
        endcase
        push_beat(8'($urandom), 1'b1);
        repeat (20) push_beat(8'($urandom), $urandom_range(0, 3) == 0);

        drain_parser();
        repeat (10) @(posedge clk);
        $display("Streamed %0d beats over %0d records with %0d name size limit writes.",
                 beats_sent, records_done, limit_writes);
        $display("The archive closed with the %s case, followed by sticky beats.",
                 ending.name());
        if (mismatches == 0 && pending == 0)
            $display("tb_cpio_newc_stream_parser passed");
        else
            $display("tb_cpio_newc_stream_parser failed");
        $finish;
    end

endmodule
